// ===== sv/csvs_pkg.sv =====
`timescale 1ns / 1ps
package csvs_pkg;

  // Parser phase within the current field
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_UNQ    = 2'd1,
    PH_QUOTED = 2'd2,
    PH_QSEEN  = 2'd3
  } csvs_phase_t;

  // Result kind codes as seen on the output channel
  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } csvs_kind_t;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_DELIMITER = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HDR_DROP  = 1'b1;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;

  typedef struct packed {
    logic [7:0] ch;
    csvs_kind_t kind;
    logic [7:0] idx;
    logic       last;
  } csvs_res_t;

  // Results produced by one accepted request: count, then in order
  typedef struct packed {
    logic [1:0] n;
    csvs_res_t  res0;
    csvs_res_t  res1;
  } csvs_push_t;

endpackage

// ===== sv/csvs_if.sv =====
`timescale 1ns / 1ps
interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_line;

  modport source (output valid, output char_in, output end_line, input ready);
  modport sink (input valid, input char_in, input end_line, output ready);
endinterface

interface csvs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] kind;
  logic [7:0] field_index;
  logic       last;

  modport source (output valid, output out_char, output kind, output field_index,
                  output last, input ready);
  modport sink (input valid, input out_char, input kind, input field_index,
                input last, output ready);
endinterface

// ===== sv/csvs_parser.sv =====
`timescale 1ns / 1ps
module csvs_parser
  import csvs_pkg::*;
#(
  parameter logic [7:0] IDX_CAP = 8'd255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               accept,
  input  logic [7:0]         char_in,
  input  logic               end_line,
  output csvs_push_t         push
);

  logic [7:0]  delim_r;
  logic        skip_hdr_r;
  csvs_phase_t phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic        has_bytes_r, has_bytes_nxt;
  logic        hdr_pend_r, hdr_pend_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  idx_inc;
  logic        dropping;

  // Saturating field index step
  assign idx_inc  = (cnt_r < IDX_CAP) ? cnt_r + 8'd1 : cnt_r;
  assign dropping = hdr_pend_r & skip_hdr_r;

  // Next state and results for the request at the input
  always_comb begin
    phase_nxt     = phase_r;
    esc_nxt       = esc_r;
    has_bytes_nxt = has_bytes_r;
    hdr_pend_nxt  = hdr_pend_r;
    cnt_nxt       = cnt_r;
    push.n        = 2'd0;
    push.res0     = '{ch: 8'd0, kind: KIND_CHAR, idx: cnt_r, last: 1'b1};
    push.res1     = '{ch: char_in, kind: KIND_CHAR, idx: idx_inc, last: 1'b1};
    if (accept) begin
      if (end_line) begin
        if (!dropping && has_bytes_r) begin
          push.n         = 2'd1;
          push.res0.kind = KIND_ROW_END;
        end
        hdr_pend_nxt  = 1'b0;
        phase_nxt     = PH_START;
        esc_nxt       = 1'b0;
        has_bytes_nxt = 1'b0;
        cnt_nxt       = 8'd0;
      end else if (!dropping) begin
        has_bytes_nxt = 1'b1;
        unique case (phase_r)
          PH_START: begin
            priority if (char_in == CH_QUOTE) begin
              phase_nxt = PH_QUOTED;
            end else if (char_in == delim_r) begin
              push.n         = 2'd1;
              push.res0.kind = KIND_FIELD_END;
              cnt_nxt        = idx_inc;
            end else begin
              push.n       = 2'd1;
              push.res0.ch = char_in;
              phase_nxt    = PH_UNQ;
            end
          end
          PH_UNQ: begin
            if (char_in == delim_r) begin
              push.n         = 2'd1;
              push.res0.kind = KIND_FIELD_END;
              cnt_nxt        = idx_inc;
              phase_nxt      = PH_START;
            end else begin
              push.n       = 2'd1;
              push.res0.ch = char_in;
            end
          end
          PH_QUOTED: begin
            priority if (esc_r) begin
              push.n       = 2'd1;
              push.res0.ch = char_in;
              esc_nxt      = 1'b0;
            end else if (char_in == CH_QUOTE) begin
              phase_nxt = PH_QSEEN;
            end else if (char_in == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else begin
              push.n       = 2'd1;
              push.res0.ch = char_in;
            end
          end
          PH_QSEEN: begin
            priority if (char_in == CH_QUOTE) begin
              // doubled quote: literal quote, stay quoted
              push.n       = 2'd1;
              push.res0.ch = CH_QUOTE;
              phase_nxt    = PH_QUOTED;
            end else if (char_in == delim_r) begin
              push.n         = 2'd1;
              push.res0.kind = KIND_FIELD_END;
              cnt_nxt        = idx_inc;
              phase_nxt      = PH_START;
            end else begin
              // stray byte: close the field, open an unquoted one
              push.n         = 2'd2;
              push.res0.kind = KIND_FIELD_END;
              push.res0.last = 1'b0;
              cnt_nxt        = idx_inc;
              phase_nxt      = PH_UNQ;
            end
          end
        endcase
      end
    end
  end

  // Hold parser state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= DELIM_RESET;
      skip_hdr_r  <= 1'b0;
      phase_r     <= PH_START;
      esc_r       <= 1'b0;
      has_bytes_r <= 1'b0;
      hdr_pend_r  <= 1'b1;
      cnt_r       <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      has_bytes_r <= has_bytes_nxt;
      hdr_pend_r  <= hdr_pend_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DELIMITER: delim_r    <= cfg_wdata;
          CFG_HDR_DROP:  skip_hdr_r <= cfg_wdata[0];
        endcase
      end
    end
  end

endmodule

// ===== sv/csvs_res_fifo.sv =====
`timescale 1ns / 1ps
module csvs_res_fifo
  import csvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  csvs_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output csvs_res_t  out_res
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = PtrW + 1;

  csvs_res_t         slot_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  // Accept a request only when both of its possible results fit
  assign room      = (count_r <= CntW'(Depth - 2));
  assign out_res   = slot_r[rd_ptr_r];

  // Store up to two results, drain one per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push.n);
      rd_ptr_r <= rd_ptr_r + PtrW'(pop);
      count_r  <= count_r + CntW'(push.n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) slot_r[wr_ptr_r] <= push.res0;
    if (push.n == 2'd2) slot_r[wr_ptr_r + PtrW'(1)] <= push.res1;
  end

endmodule

// ===== sv/csv_field_splitter.sv =====
`timescale 1ns / 1ps
// CSV field splitter: takes one text byte or one line-end marker per request and
// returns field characters, field ends and row ends tagged with the field index
// (saturating at min(MAX_FIELDS-1, 255)); quoted fields, doubled quotes, backslash
// escapes, empty-line skipping and an optional header drop are handled. A request
// is accepted whenever in_ch.ready is high; its results are held in a four-entry
// result queue and leave it one per cycle while out_ch.ready is high. A byte that
// follows a closing quote and starts a new field yields two results; in_ch.ready
// drops while fewer than two entries are free. The user must write configuration
// (index 0 delimiter, index 1 header drop) via cfg_we only when idle; unenforced.
module csv_field_splitter
  import csvs_pkg::*;
#(
  parameter int MAX_FIELDS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_wdata,
  csvs_in_if.sink            in_ch,
  csvs_out_if.source         out_ch
);

  localparam int IdxCapInt = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

  logic       accept;
  logic       room;
  csvs_push_t push;
  csvs_res_t  out_res;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid & room;

  csvs_parser #(
    .IDX_CAP (8'(IdxCapInt))
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .char_in   (in_ch.char_in),
    .end_line  (in_ch.end_line),
    .push      (push)
  );

  csvs_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Drive the result channel from the queue head
  assign out_ch.out_char    = out_res.ch;
  assign out_ch.kind        = 2'(out_res.kind);
  assign out_ch.field_index = out_res.idx;
  assign out_ch.last        = out_res.last;

endmodule

// ===== sv/csvs_checker.sv =====
`timescale 1ns / 1ps
module csvs_checker
  import csvs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [1:0] kind,
  input logic [7:0] field_index,
  input logic       last
);

  // Non-character results carry a zero byte
  a_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != 2'(KIND_CHAR) |-> out_char == 8'd0)
    else $error("non-character result with nonzero byte");

  // A row end is always the only result of its request
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == 2'(KIND_ROW_END) |-> last)
    else $error("row end not marked last");

  // Input back-pressure only while results are waiting
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

  // Nothing to deliver right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // A stalled result holds its payload
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(kind)
      && $stable(field_index) && $stable(last))
    else $error("stalled result changed");

endmodule

bind csv_field_splitter csvs_checker u_csvs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .kind        (out_ch.kind),
  .field_index (out_ch.field_index),
  .last        (out_ch.last)
);
